/* rtl/ils_pkg.sv */
// ils_pkg: shared types and constants for the indexed list store.
// Operation and status codes, FSM states, cell control bundle.
// No dependencies.
package ils_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 8;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 6;

	// read mux is split into groups of this many cells
	localparam int GRP_SIZE  = 16;
	localparam int GRP_BITS  = $clog2(GRP_SIZE);
	localparam int POS_HI_W  = POS_W - GRP_BITS;

	// value returned for a read past the end
	localparam logic signed [DATA_W-1:0] READ_MISS = -32'sd1;

	typedef enum logic [OP_W-1:0] {
		OP_READ       = 3'd0,
		OP_INS_FRONT  = 3'd1,
		OP_APPEND     = 3'd2,
		OP_INS_POS    = 3'd3,
		OP_DELETE     = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SEL  = 1'b1
	} state_t;

	// broadcast to every cell in the chain
	typedef struct packed {
		logic                     ins;
		logic                     del;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] value;
	} shift_ctrl_t;

endpackage

/* rtl/ils_req_if.sv */
// ils_req_if: request channel (op, position, value) with valid/ready.
// Depends on nothing.
interface ils_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         op;
	logic [7:0]         position;
	logic signed [31:0] value;

	modport source (output valid, op, position, value, input ready);
	modport sink   (input valid, op, position, value, output ready);
endinterface

/* rtl/ils_rsp_if.sv */
// ils_rsp_if: response channel (read_value, status, count) with valid/ready.
// Depends on nothing.
interface ils_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] read_value;
	logic [1:0]         status;
	logic [5:0]         count;

	modport source (output valid, read_value, status, count, input ready);
	modport sink   (input valid, read_value, status, count, output ready);
endinterface

/* rtl/indexed_list_store.sv */
// indexed_list_store: ordered list of signed 32-bit entries held in a
// chain of cells. Depends on ils_pkg, ils_req_if, ils_rsp_if, ils_cell,
// ils_read_sel.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   op[2:0] position[7:0] value[31:0]
//   rsp      out  valid/ready   read_value[31:0] status[1:0] count[5:0]
//
// Per request, the cells shift on the accept edge while the first read-mux
// level registers; the combinational second level then feeds the output
// register in the select state. A new request is taken only in the idle
// state, once the last result is in the output register; a stalled rsp
// holds the block in its select state until that register frees. Reset
// clears the entry count, the FSM and rsp.valid; cell contents need no reset.
module indexed_list_store #(
	parameter int DEPTH = ils_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ils_req_if.sink   req,
	ils_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	ils_pkg::state_t      state_q, state_d;
	ils_pkg::shift_ctrl_t ctrl;
	ils_pkg::status_t     status_d;
	logic                 accept;
	logic                 load_out;
	logic                 try_ins, do_ins, do_del, is_read, rd_ok;
	logic [ils_pkg::POS_W-1:0] ins_pos;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic [15:0]          cnt_w, pos_w;

	logic                 is_read_s1, rd_ok_s1;
	ils_pkg::status_t     status_s1;
	logic [ils_pkg::COUNT_W-1:0] count_s1;

	logic                               rsp_valid_q;
	logic signed [ils_pkg::DATA_W-1:0]  read_value_q;
	logic [ils_pkg::STATUS_W-1:0]       status_q;
	logic [ils_pkg::COUNT_W-1:0]        count_q;

	logic signed [ils_pkg::DATA_W-1:0]  cell_data [DEPTH];
	logic signed [ils_pkg::DATA_W-1:0]  sel_data;

	// FSM next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ils_pkg::S_IDLE: if (accept) state_d = ils_pkg::S_SEL;
			ils_pkg::S_SEL:  if (load_out) state_d = ils_pkg::S_IDLE;
			default:         state_d = ils_pkg::S_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		req.ready = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			ils_pkg::S_IDLE: req.ready = 1'b1;
			ils_pkg::S_SEL:  load_out  = !rsp_valid_q || rsp.ready;
			default: begin
				req.ready = 1'b0;
				load_out  = 1'b0;
			end
		endcase
	end

	assign accept = req.valid && req.ready;

	// request decode and range checks
	assign cnt_w = 16'(cnt_q);
	assign pos_w = 16'(req.position);

	always_comb begin
		status_d = ils_pkg::ST_RANGE;
		try_ins  = 1'b0;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		is_read  = 1'b0;
		rd_ok    = 1'b0;
		ins_pos  = req.position;
		case (req.op)
			ils_pkg::OP_READ: begin
				is_read = 1'b1;
				if (pos_w < cnt_w) begin
					rd_ok    = 1'b1;
					status_d = ils_pkg::ST_DONE;
				end
			end
			ils_pkg::OP_INS_FRONT: begin
				ins_pos = '0;
				try_ins = 1'b1;
			end
			ils_pkg::OP_APPEND: begin
				ins_pos = ils_pkg::POS_W'(cnt_q);
				try_ins = 1'b1;
			end
			ils_pkg::OP_INS_POS: begin
				if (pos_w <= cnt_w) try_ins = 1'b1;
			end
			ils_pkg::OP_DELETE: begin
				if (pos_w < cnt_w) begin
					do_del   = 1'b1;
					status_d = ils_pkg::ST_DONE;
				end
			end
			default: status_d = ils_pkg::ST_RANGE;
		endcase
		if (try_ins) begin
			if (cnt_w >= 16'(DEPTH)) begin
				status_d = ils_pkg::ST_FULL;
			end else begin
				do_ins   = 1'b1;
				status_d = ils_pkg::ST_DONE;
			end
		end
	end

	// next entry count
	always_comb begin
		cnt_d = cnt_q;
		if (do_ins) cnt_d = cnt_q + CW'(1);
		else if (do_del) cnt_d = cnt_q - CW'(1);
	end

	assign ctrl.ins   = accept && do_ins;
	assign ctrl.del   = accept && do_del;
	assign ctrl.pos   = ins_pos;
	assign ctrl.value = req.value;

	// cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [ils_pkg::DATA_W-1:0] prev_d, next_d;
		if (i == 0) begin : g_first
			assign prev_d = req.value;
		end else begin : g_mid
			assign prev_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_d = cell_data[i];
		end else begin : g_inner
			assign next_d = cell_data[i+1];
		end
		ils_cell #(.IDX(i)) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.prev_data (prev_d),
			.next_data (next_d),
			.data      (cell_data[i])
		);
	end

	ils_read_sel #(.DEPTH(DEPTH)) u_read_sel (
		.clk      (clk),
		.en       (accept),
		.pos      (req.position),
		.cells    (cell_data),
		.sel_data (sel_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ils_pkg::S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) cnt_q <= cnt_d;
			if (load_out) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	// first stage result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			is_read_s1 <= is_read;
			rd_ok_s1   <= rd_ok;
			status_s1  <= status_d;
			count_s1   <= ils_pkg::COUNT_W'(cnt_d);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (!is_read_s1) read_value_q <= '0;
			else if (rd_ok_s1) read_value_q <= sel_data;
			else read_value_q <= ils_pkg::READ_MISS;
			status_q <= status_s1;
			count_q  <= count_s1;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.status     = status_q;
	assign rsp.count      = count_q;

endmodule

/* rtl/ils_cell.sv */
// ils_cell: one list entry. Loads the new value, takes its left neighbor
// on insert, or its right neighbor on delete. Depends on ils_pkg.
module ils_cell #(
	parameter int IDX = 0
) (
	input  logic                             clk,
	input  ils_pkg::shift_ctrl_t             ctrl,
	input  logic signed [ils_pkg::DATA_W-1:0] prev_data,
	input  logic signed [ils_pkg::DATA_W-1:0] next_data,
	output logic signed [ils_pkg::DATA_W-1:0] data
);

	logic [ils_pkg::POS_W-1:0] my_idx;
	logic                      at_pos;
	logic                      past_pos;
	logic signed [ils_pkg::DATA_W-1:0] data_q;

	assign my_idx   = ils_pkg::POS_W'(IDX);
	assign at_pos   = (my_idx == ctrl.pos);
	assign past_pos = (my_idx > ctrl.pos);

	// shift or hold; contents are undefined until written
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (at_pos) begin
				data_q <= ctrl.value;
			end else if (past_pos) begin
				data_q <= prev_data;
			end
		end else if (ctrl.del) begin
			if (at_pos || past_pos) begin
				data_q <= next_data;
			end
		end
	end

	assign data = data_q;

endmodule

/* rtl/ils_read_sel.sv */
// ils_read_sel: two-level read mux over the cell chain. Registers one
// pick per group of cells, then selects the group. Depends on ils_pkg.
module ils_read_sel #(
	parameter int DEPTH = ils_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [ils_pkg::POS_W-1:0]          pos,
	input  logic signed [ils_pkg::DATA_W-1:0]  cells [DEPTH],
	output logic signed [ils_pkg::DATA_W-1:0]  sel_data
);

	localparam int NGRP = (DEPTH + ils_pkg::GRP_SIZE - 1) / ils_pkg::GRP_SIZE;

	logic signed [ils_pkg::DATA_W-1:0] cand    [NGRP][ils_pkg::GRP_SIZE];
	logic signed [ils_pkg::DATA_W-1:0] grp_s1  [NGRP];
	logic [ils_pkg::POS_HI_W-1:0]      pos_hi_s1;

	// map cells into groups, padding the last group
	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		for (genvar j = 0; j < ils_pkg::GRP_SIZE; j++) begin : g_slot
			if (g * ils_pkg::GRP_SIZE + j < DEPTH) begin : g_real
				assign cand[g][j] = cells[g * ils_pkg::GRP_SIZE + j];
			end else begin : g_pad
				assign cand[g][j] = '0;
			end
		end
	end

	// first level: pick within each group
	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < NGRP; g++) begin
				grp_s1[g] <= cand[g][pos[ils_pkg::GRP_BITS-1:0]];
			end
			pos_hi_s1 <= pos[ils_pkg::POS_W-1:ils_pkg::GRP_BITS];
		end
	end

	// second level: pick the group
	always_comb begin
		sel_data = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (pos_hi_s1 == ils_pkg::POS_HI_W'(g)) begin
				sel_data = grp_s1[g];
			end
		end
	end

endmodule
